### rtl/unique_fifo_queue_defines.svh
// assertion macros for the deduplicating queue
`ifndef UNIQUE_FIFO_QUEUE_DEFINES_SVH
`define UNIQUE_FIFO_QUEUE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UFQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define UFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ufq_pkg.sv
// shared types and constants of the deduplicating queue
package ufq_pkg;

	// default sizes
	localparam int unsigned DEF_QUEUE_DEPTH = 16;
	localparam int unsigned DEF_VALUE_WIDTH = 32;

	// opcodes on the input tuser
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// push status codes
	localparam logic [1:0] PUSH_ADDED    = 2'd0;
	localparam logic [1:0] PUSH_DUP      = 2'd1;
	localparam logic [1:0] PUSH_FULL     = 2'd2;
	localparam logic [1:0] PUSH_NOT_PUSH = 2'd3;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP_RD,
		ST_FINISH
	} ufq_state_t;

endpackage

### rtl/unique_fifo_queue.sv
// deduplicating fifo: one shared compare unit sweeps the held entries per push
//
// channel  dir  tdata                                 tuser
// s_*      in   [31:0] item_value                     [0] opcode
// m_*      out  [31:0] pop_value, [36:32] entry_count [0] pop_valid, [2:1] push_status
//
// a pop reads the head entry in its read step before it finishes (an empty queue goes straight to finish); a push
// scans every held entry before it finishes (an empty queue finishes at once, a duplicate hit stops the scan early),
// paced by the single comparator that reads one stored entry per cycle from the memory.
// s_tready is high only while the sequencer is idle; a waiting result does not block it.
// a stalled m_tready holds the sequencer in its finish step until the result register frees.
// arst_n clears pointers, count and control; the entry memory is not cleared.
`include "unique_fifo_queue_defines.svh"

module unique_fifo_queue #(
	parameter int unsigned QUEUE_DEPTH = ufq_pkg::DEF_QUEUE_DEPTH,
	parameter int unsigned VALUE_WIDTH = ufq_pkg::DEF_VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] item_value
	input  logic [0:0]  s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] pop_value, [36:32] entry_count, rest zero
	output logic [2:0]  m_tuser    // [0] pop_valid, [2:1] push_status
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

	// wrap a slot pointer
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
		logic [PTR_W-1:0] r;
		r = (s == LAST_SLOT) ? '0 : s + 1'b1;
		return r;
	endfunction

	ufq_pkg::ufq_state_t state_q, state_d;

	logic                   op_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [PTR_W-1:0]       head_q, tail_q, scan_ptr_q;
	logic [CNT_W-1:0]       count_q, scan_left_q;
	logic                   cmp_pend_q, dup_q;
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic [PTR_W-1:0]       rd_addr;
	logic                   mem_we;

	logic                   out_valid_q;
	logic                   pop_valid_q;
	logic [31:0]            pop_value_q;
	logic [1:0]             push_status_q;
	logic [4:0]             entry_count_q;

	logic                   in_fire, finish_fire, issue, hit;
	logic                   res_pop_valid;
	logic [1:0]             res_status;
	logic [CNT_W-1:0]       count_next;
	logic [63:0]            in_ext, rd_ext;
	logic [31:0]            count_ext;

	// entry memory, one write and one registered read port
	logic [VALUE_WIDTH-1:0] mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= value_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	// width conversions of values
	assign in_ext = 64'($signed(s_tdata));
	assign rd_ext = 64'($signed(rd_data_q));

	// shared comparator and scan issue
	assign issue = (scan_left_q != '0);
	assign hit   = cmp_pend_q && (rd_data_q == value_q);
	assign rd_addr = (state_q == ufq_pkg::ST_SCAN) ? scan_ptr_q : head_q;

	// result of the item now finishing
	always_comb begin
		res_pop_valid = 1'b0;
		res_status    = ufq_pkg::PUSH_NOT_PUSH;
		count_next    = count_q;
		if (op_q == ufq_pkg::OP_PUSH) begin
			if (dup_q) begin
				res_status = ufq_pkg::PUSH_DUP;
			end else if (count_q >= FULL_CNT) begin
				res_status = ufq_pkg::PUSH_FULL;
			end else begin
				res_status = ufq_pkg::PUSH_ADDED;
				count_next = count_q + 1'b1;
			end
		end else if (count_q != '0) begin
			res_pop_valid = 1'b1;
			count_next    = count_q - 1'b1;
		end
	end

	assign count_ext = 32'(count_next);

	// sequencer next state and handshakes
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		in_fire     = 1'b0;
		finish_fire = 1'b0;
		mem_we      = 1'b0;
		case (state_q)
			ufq_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				in_fire  = s_tvalid;
				if (s_tvalid) begin
					if (s_tuser[0] == ufq_pkg::OP_PUSH) begin
						state_d = ufq_pkg::ST_SCAN;
					end else if (count_q != '0) begin
						state_d = ufq_pkg::ST_POP_RD;
					end else begin
						state_d = ufq_pkg::ST_FINISH;
					end
				end
			end
			ufq_pkg::ST_SCAN: begin
				if (hit || (!issue && !cmp_pend_q)) begin
					state_d = ufq_pkg::ST_FINISH;
				end
			end
			ufq_pkg::ST_POP_RD: begin
				state_d = ufq_pkg::ST_FINISH;
			end
			ufq_pkg::ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					finish_fire = 1'b1;
					mem_we  = (op_q == ufq_pkg::OP_PUSH) && (res_status == ufq_pkg::PUSH_ADDED);
					state_d = ufq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ufq_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item capture, scan pointers and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= ufq_pkg::OP_PUSH;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			cmp_pend_q  <= 1'b0;
			dup_q       <= 1'b0;
		end else begin
			if (in_fire) begin
				op_q        <= s_tuser[0];
				scan_ptr_q  <= head_q;
				scan_left_q <= count_q;
				cmp_pend_q  <= 1'b0;
				dup_q       <= 1'b0;
			end else if (state_q == ufq_pkg::ST_SCAN) begin
				cmp_pend_q <= issue;
				if (issue) begin
					scan_ptr_q  <= next_slot(scan_ptr_q);
					scan_left_q <= scan_left_q - 1'b1;
				end
				if (hit) begin
					dup_q <= 1'b1;
				end
			end
			if (finish_fire) begin
				count_q <= count_next;
				if (res_pop_valid) begin
					head_q <= next_slot(head_q);
				end
				if (mem_we) begin
					tail_q <= next_slot(tail_q);
				end
			end
		end
	end

	// pushed value, kept to the stored width
	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_q <= in_ext[VALUE_WIDTH-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_fire) begin
			pop_valid_q   <= res_pop_valid;
			pop_value_q   <= res_pop_valid ? rd_ext[31:0] : 32'd0;
			push_status_q <= res_status;
			entry_count_q <= count_ext[4:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, entry_count_q, pop_value_q};
	assign m_tuser  = {push_status_q, pop_valid_q};

	// checks
	`UFQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FULL_CNT, "held count above depth")
	`UFQ_ASSERT_NOW(a_scan_bound, state_q == ufq_pkg::ST_SCAN, scan_left_q <= count_q,
		"scan runs past held entries")
	`UFQ_ASSERT_NOW(a_pop_status, m_tvalid && m_tuser[0],
		m_tuser[2:1] == ufq_pkg::PUSH_NOT_PUSH, "popped item carries a push status")
	`UFQ_ASSERT_NEXT(a_count_hold, state_q != ufq_pkg::ST_FINISH, $stable(count_q),
		"count changed outside finish step")

endmodule

### tb/tb_unique_fifo_queue.sv
// self-checking testbench for the deduplicating fifo queue
`timescale 1ns / 1ps

module tb_unique_fifo_queue;

	// one command for the input side
	typedef struct packed {
		logic        op;
		logic [31:0] value;
		logic [4:0]  gap;
		logic        wait_drain;
	} queue_cmd_t;

	// one result as seen on the output side
	typedef struct packed {
		logic        pop_valid;
		logic [31:0] pop_value;
		logic [1:0]  push_status;
		logic [4:0]  entry_count;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] item_value
	logic [0:0]  s_tuser = '0;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [31:0] pop_value, [36:32] entry_count
	logic [2:0]  m_tuser;        // [0] pop_valid, [2:1] push_status

	// model copy of the held entries, oldest first
	logic [31:0]   held_values[$];
	queue_result_t expected_results[$];
	queue_cmd_t    pending_cmds[$];

	// driver state
	queue_cmd_t cur_cmd = '0;
	bit         cmd_loaded = 1'b0;
	int         gap_left = 0;

	// monitor state
	queue_result_t got_result;
	queue_result_t want_result;
	int            rx_stall = 0;
	int            rx_calm_left = 0;
	logic          hold_off = 1'b0;

	// run statistics
	int items_accepted = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int added_count = 0;
	int dup_count = 0;
	int full_count = 0;
	int pop_count = 0;
	int empty_pop_count = 0;

	unique_fifo_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// reset held at the start, released away from the rising edge
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// apply one item to the model queue and return the result it should give
	function automatic queue_result_t dedup_step(input logic op, input logic [31:0] value);
		queue_result_t res;
		bit            already;
		int            k;
		res = '0;
		res.push_status = ufq_pkg::PUSH_NOT_PUSH;
		if (op == ufq_pkg::OP_PUSH) begin
			already = 1'b0;
			for (k = 0; k < held_values.size(); k++)
				if (held_values[k] == value)
					already = 1'b1;
			// duplicate check wins over the full check
			if (already) begin
				res.push_status = ufq_pkg::PUSH_DUP;
				dup_count++;
			end else if (held_values.size() >= ufq_pkg::DEF_QUEUE_DEPTH) begin
				res.push_status = ufq_pkg::PUSH_FULL;
				full_count++;
			end else begin
				held_values.push_back(value);
				res.push_status = ufq_pkg::PUSH_ADDED;
				added_count++;
			end
		end else if (held_values.size() > 0) begin
			res.pop_valid = 1'b1;
			res.pop_value = held_values.pop_front();
			pop_count++;
		end else begin
			empty_pop_count++;
		end
		res.entry_count = 5'(held_values.size());
		return res;
	endfunction

	task automatic add_cmd(input logic op, input logic [31:0] value, input int gap,
			input bit wait_drain);
		queue_cmd_t c;
		c.op = op;
		c.value = value;
		c.gap = 5'(gap);
		c.wait_drain = wait_drain;
		pending_cmds.push_back(c);
	endtask

	// driver: offer queued items, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			cmd_loaded = 1'b0;
			gap_left = 0;
		end else begin
			// item taken by the block
			if (s_tvalid && s_tready) begin
				expected_results.push_back(dedup_step(cur_cmd.op, cur_cmd.value));
				items_accepted++;
				cmd_loaded = 1'b0;
			end
			// load the next item once the current one is gone
			if (!cmd_loaded && pending_cmds.size() > 0) begin
				cur_cmd = pending_cmds.pop_front();
				gap_left = cur_cmd.gap;
				cmd_loaded = 1'b1;
			end
			// keep a waiting item, else idle cycles first, then offer
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (cmd_loaded && gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (cmd_loaded && (!cur_cmd.wait_drain || expected_results.size() == 0)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= cur_cmd.value;
				s_tuser  <= cur_cmd.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: take results with random stalls and check each field
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_result.pop_valid   = m_tuser[0];
				got_result.push_status = m_tuser[2:1];
				got_result.pop_value   = m_tdata[31:0];
				got_result.entry_count = m_tdata[36:32];
				results_checked++;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("ERROR: unexpected result v=%0b val=%h st=%0d cnt=%0d",
							got_result.pop_valid, got_result.pop_value,
							got_result.push_status, got_result.entry_count);
				end else begin
					want_result = expected_results.pop_front();
					if (got_result.pop_valid !== want_result.pop_valid ||
							got_result.pop_value !== want_result.pop_value ||
							got_result.push_status !== want_result.push_status ||
							got_result.entry_count !== want_result.entry_count) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("ERROR: result %0d exp %0b/%h/%0d/%0d got %0b/%h/%0d/%0d",
								results_checked, want_result.pop_valid,
								want_result.pop_value, want_result.push_status,
								want_result.entry_count, got_result.pop_valid,
								got_result.pop_value, got_result.push_status,
								got_result.entry_count);
					end
				end
				// stall draw, with calm stretches now and then
				if (rx_calm_left > 0) begin
					rx_calm_left--;
					rx_stall = 0;
				end else if ($urandom_range(0, 7) == 0) begin
					rx_calm_left = $urandom_range(20, 60);
					rx_stall = 0;
				end else begin
					rx_stall = $urandom_range(0, 16);
				end
			end
			m_tready <= !hold_off && rx_stall == 0;
			if (rx_stall > 0)
				rx_stall--;
		end
	end

	// long receiver hold-off so the result register stays full and the block stalls its input
	initial begin
		while (items_accepted < 200)
			@(posedge clk);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	// stimulus and end of run
	initial begin
		logic [31:0] value_pool[0:23];
		int          i;
		int          blk;
		int          push_pct;
		int          gap_mode;
		int          gap;
		logic [31:0] value;
		logic        op;

		// directed: extremes, empty pop, fill to full, duplicate in full store
		add_cmd(ufq_pkg::OP_POP, 32'h0, 2, 1'b0);
		add_cmd(ufq_pkg::OP_PUSH, 32'h0000_0000, 0, 1'b0);
		add_cmd(ufq_pkg::OP_PUSH, 32'h7FFF_FFFF, 1, 1'b0);
		add_cmd(ufq_pkg::OP_PUSH, 32'h8000_0000, 0, 1'b0);
		add_cmd(ufq_pkg::OP_PUSH, 32'hFFFF_FFFF, 3, 1'b0);
		add_cmd(ufq_pkg::OP_PUSH, 32'h8000_0000, 0, 1'b0);
		for (i = 1; i <= 12; i++)
			add_cmd(ufq_pkg::OP_PUSH, 32'h1000_0000 + i, $urandom_range(0, 3), 1'b0);
		add_cmd(ufq_pkg::OP_PUSH, 32'h2000_0000, 0, 1'b0);
		add_cmd(ufq_pkg::OP_PUSH, 32'hFFFF_FFFF, 1, 1'b0);
		add_cmd(ufq_pkg::OP_POP, 32'h0, 0, 1'b0);
		add_cmd(ufq_pkg::OP_POP, 32'h0, 2, 1'b0);
		add_cmd(ufq_pkg::OP_POP, 32'h0, 0, 1'b0);
		add_cmd(ufq_pkg::OP_PUSH, 32'h0000_0000, 0, 1'b0);
		add_cmd(ufq_pkg::OP_POP, 32'hFFFF_FFFF, 0, 1'b0);

		// small value pool so duplicates are common
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		value_pool[4] = 32'h0000_0001;
		for (i = 5; i < 24; i++)
			value_pool[i] = $urandom;

		// random blocks with varying push bias and gap style
		for (blk = 0; blk < 16; blk++) begin
			case ($urandom_range(0, 3))
				0: push_pct = 25;
				1: push_pct = 50;
				2: push_pct = 75;
				default: push_pct = 95;
			endcase
			gap_mode = $urandom_range(0, 2);
			for (i = 0; i < 100; i++) begin
				op = ($urandom_range(1, 100) <= push_pct) ? ufq_pkg::OP_PUSH : ufq_pkg::OP_POP;
				if (op == ufq_pkg::OP_PUSH && $urandom_range(0, 9) < 6)
					value = value_pool[$urandom_range(0, 23)];
				else
					value = $urandom;
				case (gap_mode)
					0: gap = 0;
					1: gap = $urandom_range(0, 16);
					default: gap = $urandom_range(0, 2);
				endcase
				// pause for a full drain at the start and midway
				add_cmd(op, value, gap, i == 0 && (blk == 0 || blk == 8));
			end
		end

		// wait for every item to be taken, then for every result
		while (pending_cmds.size() != 0 || cmd_loaded || s_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		$display("items %0d: %0d added, %0d duplicate, %0d full, %0d pops, %0d empty pops",
			items_accepted, added_count, dup_count, full_count, pop_count, empty_pop_count);
		$display("results checked %0d, mismatches %0d", results_checked, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("** unique_fifo_queue: PASSED **");
		else
			$display("** unique_fifo_queue: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#(5_000_000);
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("** unique_fifo_queue: FAILED **");
		$finish;
	end

endmodule
